FILE: hdl/cgt_pkg.sv
// ---------------------------------------------------------------------------
// cgt_pkg - shared constants for the colour gradient table
// Sizes of the stop store, the table index, the serial divider and the
// command, status and register codes.
// ---------------------------------------------------------------------------
package cgt_pkg;

  localparam int MAX_STOPS      = 16;
  localparam int MAX_RESOLUTION = 4096;

  localparam int STOP_W  = $clog2(MAX_STOPS);          // stop store address
  localparam int COUNT_W = $clog2(MAX_STOPS) + 1;      // stop count, 0..MAX_STOPS
  localparam int SEGS_W  = COUNT_W;                    // segments, 0..MAX_STOPS
  localparam int RES_W   = 13;                         // resolution register
  localparam int IDX_W   = 12;                         // table index
  localparam int D_W     = $clog2(MAX_RESOLUTION);     // resolution - 1
  localparam int N_W     = D_W + STOP_W;               // index * segments
  localparam int DIV_W   = D_W + 1;                    // divisor and remainder
  localparam int COL_W   = 8;                          // one colour byte
  localparam int RGB_W   = 3 * COL_W;
  localparam int PROD_W  = COL_W + D_W;                // |b - a| * rem
  localparam int NUM_W   = PROD_W + 1;                 // 2*|b - a|*rem + D
  localparam int CNT_W   = $clog2(N_W);

  localparam logic [CNT_W-1:0] SEG_STEPS_LAST = CNT_W'(N_W - 1);
  localparam logic [CNT_W-1:0] CH_STEPS_LAST  = CNT_W'(COL_W - 1);

  // Command codes carried in kind
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_STOPS = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_AROUND = 2'd1;

  localparam logic [RES_W-1:0] RESOLUTION_RESET = 13'd256;
  localparam logic             WRAP_RESET       = 1'b1;

endpackage

FILE: hdl/color_gradient_table_core.sv
// ---------------------------------------------------------------------------
// color_gradient_table_core - piecewise-linear RGB gradient lookup
// Holds up to MAX_STOPS colour stops and answers table queries by linear
// interpolation between neighbouring stops, using one bit-serial divider.
// ---------------------------------------------------------------------------
//
//  channel   signals                                 role
//  -------   -------------------------------------   ---------------------------
//  item      item_valid/item_ready, kind, stop_*,    command in: append, query,
//            entry_index                             clear
//  result    result_valid/result_ready, out_*,       one transfer per query
//            status
//  config    cfg_we, cfg_index, cfg_data             register write, no wait
//
//  A query with a full interpolation runs from transfer to the next free
//  item slot through 16 steps of the radix-2 divider for the segment
//  number, ST_SEG_FIX and ST_FETCH_A/B/C to fix the segment and fetch both
//  stops, then per colour byte one multiply, one load, 8 divider steps and
//  one shift, and ST_OUT to hand the result over. One divider is shared by
//  segment number and colour bytes. Append and clear stay in ST_IDLE; an
//  error query goes straight to ST_OUT, a query with no segment or a one-entry table through ST_FETCH_A and ST_FETCH_B.
//  Reset (rst, synchronous) empties the stop store, sets resolution to 256
//  and wrap_around to 1; the stop store contents are left as they were.
//  A finished result waits in the output register; the core only holds in
//  its final state while an earlier result is still untaken.
//
module color_gradient_table_core import cgt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [1:0]           kind,
  input  logic [COL_W-1:0]     stop_red,
  input  logic [COL_W-1:0]     stop_green,
  input  logic [COL_W-1:0]     stop_blue,
  input  logic [IDX_W-1:0]     entry_index,

  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [COL_W-1:0]     out_red,
  output logic [COL_W-1:0]     out_green,
  output logic [COL_W-1:0]     out_blue,
  output logic [1:0]           status,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RES_W-1:0]     cfg_data
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_SEG_DIV = 11'b000_0000_0010,
    ST_SEG_FIX = 11'b000_0000_0100,
    ST_FETCH_A = 11'b000_0000_1000,
    ST_FETCH_B = 11'b000_0001_0000,
    ST_FETCH_C = 11'b000_0010_0000,
    ST_CH_MUL  = 11'b000_0100_0000,
    ST_CH_LOAD = 11'b000_1000_0000,
    ST_CH_DIV  = 11'b001_0000_0000,
    ST_CH_DONE = 11'b010_0000_0000,
    ST_OUT     = 11'b100_0000_0000
  } state_t;

  state_t state;

  // Configuration and stop count
  logic [RES_W-1:0]   resolution;
  logic               wrap_around;
  logic [COUNT_W-1:0] stop_count;

  // Stop store with a registered read port
  logic [RGB_W-1:0]  stop_mem [MAX_STOPS];
  logic [RGB_W-1:0]  mem_q;
  logic              rd_en;
  logic [STOP_W-1:0] rd_addr;

  // Per-query working registers
  logic [D_W-1:0]    d_r;
  logic [SEGS_W-1:0] segs_r;
  logic [D_W-1:0]    rem_r;
  logic [STOP_W-1:0] first;
  logic [STOP_W-1:0] second;
  logic              direct;
  logic [RGB_W-1:0]  stop_a;
  logic [RGB_W-1:0]  stop_b;
  logic [RGB_W-1:0]  res_col;
  logic [1:0]        res_stat;
  logic [1:0]        ch_cnt;
  logic [PROD_W-1:0] prod;
  logic              neg;

  // Bit-serial restoring divider
  logic [DIV_W-1:0]  div_rem;
  logic [DIV_W-1:0]  div_div;
  logic [N_W-1:0]    div_sh;
  logic [CNT_W-1:0]  div_cnt;
  logic [DIV_W:0]    div_t;
  logic              div_ge;

  // Combinational helpers
  logic              item_xfer;
  logic              out_load;
  logic [RES_W-1:0]  res_eff;
  logic [D_W-1:0]    d_cur;
  logic [SEGS_W-1:0] segs_cur;
  logic [COL_W-1:0]  a_byte;
  logic [COL_W-1:0]  b_byte;
  logic [COL_W-1:0]  mag;
  logic [COL_W-1:0]  ch_out;
  logic [NUM_W-1:0]  dividend;
  logic              seg_clamp;
  logic [STOP_W-1:0] seg_sel;
  logic [COUNT_W-1:0] seg_inc;

  assign item_ready = (state == ST_IDLE);
  assign item_xfer  = item_valid && item_ready;
  assign out_load   = (state == ST_OUT) && (!result_valid || result_ready);

  // Resolution saturates at the table maximum
  assign res_eff  = (resolution > RES_W'(MAX_RESOLUTION)) ? RES_W'(MAX_RESOLUTION)
                                                           : resolution;
  assign d_cur    = D_W'(res_eff - RES_W'(1));
  assign segs_cur = SEGS_W'(stop_count - COUNT_W'(1) + COUNT_W'(wrap_around));

  // One divider step: bring down the next dividend bit, subtract if it fits
  assign div_t  = {div_rem, div_sh[N_W-1]};
  assign div_ge = (div_t >= {1'b0, div_div});

  // Segment number: the quotient can only reach segs when the index is the
  // last entry, and then the remainder is the whole of D
  assign seg_clamp = (div_sh >= N_W'(segs_r));
  assign seg_sel   = seg_clamp ? STOP_W'(segs_r - SEGS_W'(1)) : div_sh[STOP_W-1:0];
  assign seg_inc   = COUNT_W'(seg_sel) + COUNT_W'(1);

  // Colour byte under work sits in the top byte of the rotating stop words
  assign a_byte = stop_a[RGB_W-1 -: COL_W];
  assign b_byte = stop_b[RGB_W-1 -: COL_W];
  assign mag    = (b_byte < a_byte) ? (a_byte - b_byte) : (b_byte - a_byte);

  // Rising: a + floor((2*d*rem + D) / 2D); falling: a - floor((2*d*rem + D-1) / 2D)
  assign dividend = {prod, 1'b0} + NUM_W'(d_r) - NUM_W'(neg);
  assign ch_out   = neg ? (a_byte - div_sh[COL_W-1:0]) : (a_byte + div_sh[COL_W-1:0]);

  assign rd_en   = (state == ST_FETCH_A) || (state == ST_FETCH_B);
  assign rd_addr = (state == ST_FETCH_A) ? first : second;

  // Stop store
  always_ff @(posedge clk) begin
    if (item_xfer && (kind == KIND_APPEND) && (stop_count < COUNT_W'(MAX_STOPS))) begin
      stop_mem[stop_count[STOP_W-1:0]] <= {stop_red, stop_green, stop_blue};
    end
    if (rd_en) begin
      mem_q <= stop_mem[rd_addr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution  <= RESOLUTION_RESET;
      wrap_around <= WRAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESOLUTION:  resolution  <= cfg_data;
        CFG_WRAP_AROUND: wrap_around <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control: sequencer, stop count, channel counter, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stop_count   <= '0;
      ch_cnt       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (item_xfer) begin
            case (kind)
              KIND_APPEND: begin
                if (stop_count < COUNT_W'(MAX_STOPS)) begin
                  stop_count <= stop_count + COUNT_W'(1);
                end
              end
              KIND_CLEAR: stop_count <= '0;
              KIND_QUERY: begin
                ch_cnt <= '0;
                if ((stop_count == '0) || (RES_W'(entry_index) >= res_eff)) begin
                  state <= ST_OUT;
                end else if ((segs_cur == '0) || (res_eff == RES_W'(1))) begin
                  state <= ST_FETCH_A;
                end else begin
                  state <= ST_SEG_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SEG_DIV: begin
          if (div_cnt == '0) begin
            state <= ST_SEG_FIX;
          end
        end
        ST_SEG_FIX: state <= ST_FETCH_A;
        ST_FETCH_A: state <= ST_FETCH_B;
        ST_FETCH_B: state <= direct ? ST_OUT : ST_FETCH_C;
        ST_FETCH_C: state <= ST_CH_MUL;
        ST_CH_MUL:  state <= ST_CH_LOAD;
        ST_CH_LOAD: state <= ST_CH_DIV;
        ST_CH_DIV: begin
          if (div_cnt == '0) begin
            state <= ST_CH_DONE;
          end
        end
        ST_CH_DONE: begin
          if (ch_cnt == 2'd2) begin
            state <= ST_OUT;
          end else begin
            ch_cnt <= ch_cnt + 2'd1;
            state  <= ST_CH_MUL;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath: divider, stop words, result bytes
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        res_col  <= '0;
        first    <= '0;
        d_r      <= d_cur;
        segs_r   <= segs_cur;
        // Errors, segment-free tables and one-entry tables skip the divider
        direct   <= (stop_count == '0) || (RES_W'(entry_index) >= res_eff) ||
                    (segs_cur == '0) || (res_eff == RES_W'(1));
        if (stop_count == '0) begin
          res_stat <= STATUS_NO_STOPS;
        end else if (RES_W'(entry_index) >= res_eff) begin
          res_stat <= STATUS_RANGE;
        end else begin
          res_stat <= STATUS_OK;
        end
        // Load the divider with index * segments over D
        div_rem <= '0;
        div_div <= DIV_W'(d_cur);
        div_sh  <= N_W'(entry_index * segs_cur);
        div_cnt <= SEG_STEPS_LAST;
      end
      ST_SEG_DIV, ST_CH_DIV: begin
        div_rem <= div_ge ? DIV_W'(div_t - {1'b0, div_div}) : div_t[DIV_W-1:0];
        div_sh  <= {div_sh[N_W-2:0], div_ge};
        div_cnt <= div_cnt - CNT_W'(1);
      end
      ST_SEG_FIX: begin
        first  <= seg_sel;
        second <= (seg_inc >= stop_count) ? '0 : seg_inc[STOP_W-1:0];
        rem_r  <= seg_clamp ? d_r : div_rem[D_W-1:0];
      end
      ST_FETCH_B: begin
        stop_a <= mem_q;
        if (direct) begin
          res_col <= mem_q;
        end
      end
      ST_FETCH_C: stop_b <= mem_q;
      ST_CH_MUL: begin
        neg  <= (b_byte < a_byte);
        prod <= mag * rem_r;
      end
      ST_CH_LOAD: begin
        // Quotient stays below 256, so the top bits already sit under 2D
        div_rem <= dividend[NUM_W-1 -: DIV_W];
        div_sh  <= N_W'({dividend[COL_W-1:0], {COL_W{1'b0}}});
        div_div <= {d_r, 1'b0};
        div_cnt <= CH_STEPS_LAST;
      end
      ST_CH_DONE: begin
        res_col <= {res_col[RGB_W-COL_W-1:0], ch_out};
        stop_a  <= {stop_a[RGB_W-COL_W-1:0], a_byte};
        stop_b  <= {stop_b[RGB_W-COL_W-1:0], b_byte};
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red   <= res_col[RGB_W-1 -: COL_W];
      out_green <= res_col[RGB_W-COL_W-1 -: COL_W];
      out_blue  <= res_col[COL_W-1:0];
      status    <= res_stat;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stop_count <= COUNT_W'(MAX_STOPS))
    else $error("stop count beyond capacity");

  a_div_rem_below: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SEG_DIV) || (state == ST_CH_DIV)) |-> (div_rem < div_div))
    else $error("divider remainder not below divisor");

  a_no_stops: assert property (@(posedge clk) disable iff (rst)
    (item_xfer && (kind == KIND_QUERY) && (stop_count == '0))
      |=> ((state == ST_OUT) && (res_stat == STATUS_NO_STOPS)))
    else $error("empty-store query did not report no stops");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != STATUS_OK))
      |-> ((out_red == '0) && (out_green == '0) && (out_blue == '0)))
    else $error("error result carries colour");

  a_second_stop: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FETCH_A) && !direct)
      |-> ((COUNT_W'(second) < stop_count) && (COUNT_W'(first) < stop_count)))
    else $error("segment stop beyond stop count");
`endif

endmodule
